FILE: hdl/tffb_pkg.sv
// ----------------------------------------------------------------------------
// tffb_pkg
// Shared types, widths and codes of the triangle fill framebuffer engine.
// ----------------------------------------------------------------------------
package tffb_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int COORD_W   = 16;
    localparam int EXT_W     = COORD_W + 1;
    localparam int PROD_W    = 2 * EXT_W;
    localparam int EDGE_W    = 37;
    localparam int COLOR_W   = 32;
    localparam int DIM_REG_W = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [DIM_REG_W-1:0] DIM_RESET = 7'd64;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_FILL  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    typedef struct packed {
        logic               we;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } pix_wr_t;

    function automatic logic signed [EXT_W-1:0] active_dim(
        input logic [DIM_REG_W-1:0] reg_val,
        input int                   max_dim
    );
        logic signed [EXT_W-1:0] ext;
        ext = $signed({{(EXT_W-DIM_REG_W){1'b0}}, reg_val});
        if (int'(reg_val) > max_dim)
        begin
            return EXT_W'(max_dim);
        end
        return ext;
    endfunction

endpackage

FILE: hdl/tffb_store.sv
// ----------------------------------------------------------------------------
// tffb_store
// Single-port frame memory with a registered read port.
// ----------------------------------------------------------------------------
module tffb_store #(
    parameter int DEPTH  = tffb_pkg::DEF_MAX_WIDTH * tffb_pkg::DEF_MAX_HEIGHT,
    parameter int ADDR_W = 12
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [ADDR_W-1:0]            addr,
    input  logic [tffb_pkg::COLOR_W-1:0] wdata,
    output logic [tffb_pkg::COLOR_W-1:0] rdata
);

    logic [tffb_pkg::COLOR_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: hdl/tffb_raster.sv
// ----------------------------------------------------------------------------
// tffb_raster
// Triangle setup and bounding box scan with incrementally stepped edge
// functions; issues one pixel write request per covered pixel.
// ----------------------------------------------------------------------------
module tffb_raster (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [tffb_pkg::COORD_W-1:0] ax,
    input  logic signed [tffb_pkg::COORD_W-1:0] ay,
    input  logic signed [tffb_pkg::COORD_W-1:0] bx,
    input  logic signed [tffb_pkg::COORD_W-1:0] by_coord,
    input  logic signed [tffb_pkg::COORD_W-1:0] cx,
    input  logic signed [tffb_pkg::COORD_W-1:0] cy,
    input  logic signed [tffb_pkg::EXT_W-1:0]   act_w,
    input  logic signed [tffb_pkg::EXT_W-1:0]   act_h,
    output tffb_pkg::pix_wr_t                   wr,
    output logic                                finish
);

    localparam int CW = tffb_pkg::COORD_W;
    localparam int XW = tffb_pkg::EXT_W;
    localparam int PW = tffb_pkg::PROD_W;
    localparam int EW = tffb_pkg::EDGE_W;

    localparam logic signed [EW-1:0] EDGE_ZERO = '0;

    localparam logic [2:0] R_IDLE  = 3'd0;
    localparam logic [2:0] R_CLIP  = 3'd1;
    localparam logic [2:0] R_MULT  = 3'd2;
    localparam logic [2:0] R_SETUP = 3'd3;
    localparam logic [2:0] R_SCAN  = 3'd4;

    function automatic logic signed [CW-1:0] min3(
        input logic signed [CW-1:0] a,
        input logic signed [CW-1:0] b,
        input logic signed [CW-1:0] c
    );
        logic signed [CW-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [CW-1:0] max3(
        input logic signed [CW-1:0] a,
        input logic signed [CW-1:0] b,
        input logic signed [CW-1:0] c
    );
        logic signed [CW-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    logic [2:0] state_reg;

    logic signed [XW-1:0] e1x_reg, e1y_reg, e2x_reg, e2y_reg;
    logic signed [CW-1:0] x1_reg, y1_reg;
    logic signed [CW-1:0] lox_reg, hix_reg, loy_reg, hiy_reg;
    logic signed [XW-1:0] x_lo_reg, x_hi_reg, y_lo_reg, y_hi_reg;
    logic signed [XW-1:0] vx0_reg, vy0_reg;
    logic signed [PW-1:0] pda_reg, pdb_reg, psa_reg, psb_reg, pta_reg, ptb_reg;
    logic signed [EW-1:0] det_reg, s_reg, t_reg, s_col_reg, t_col_reg;
    logic signed [XW-1:0] x_reg, y_reg;

    logic signed [XW-1:0] lox_ext, hix_ext, loy_ext, hiy_ext;
    logic signed [XW-1:0] aw_m1, ah_m1;
    logic signed [XW-1:0] lox_c, hix_c, loy_c, hiy_c;
    logic signed [EW-1:0] det_calc, s_calc, t_calc;
    logic signed [EW:0]   st_sum;
    logic                 box_empty;
    logic                 covered;
    logic                 last_row;
    logic                 last_col;

    assign lox_ext = {lox_reg[CW-1], lox_reg};
    assign hix_ext = {hix_reg[CW-1], hix_reg};
    assign loy_ext = {loy_reg[CW-1], loy_reg};
    assign hiy_ext = {hiy_reg[CW-1], hiy_reg};
    assign aw_m1   = act_w - XW'(1);
    assign ah_m1   = act_h - XW'(1);
    assign lox_c   = lox_ext[XW-1] ? '0 : lox_ext;
    assign loy_c   = loy_ext[XW-1] ? '0 : loy_ext;
    assign hix_c   = (hix_ext > aw_m1) ? aw_m1 : hix_ext;
    assign hiy_c   = (hiy_ext > ah_m1) ? ah_m1 : hiy_ext;

    assign det_calc  = EW'(pda_reg) - EW'(pdb_reg);
    assign s_calc    = EW'(psa_reg) - EW'(psb_reg);
    assign t_calc    = EW'(pta_reg) - EW'(ptb_reg);
    assign box_empty = (det_calc == '0) || (x_lo_reg > x_hi_reg) || (y_lo_reg > y_hi_reg);

    assign st_sum = (EW+1)'(s_reg) + (EW+1)'(t_reg);

    always_comb
    begin
        if (det_reg[EW-1])
        begin
            covered = (s_reg <= EDGE_ZERO) && (t_reg <= EDGE_ZERO)
                   && (st_sum >= (EW+1)'(det_reg));
        end
        else
        begin
            covered = (s_reg >= EDGE_ZERO) && (t_reg >= EDGE_ZERO)
                   && (st_sum <= (EW+1)'(det_reg));
        end
    end

    assign last_row = (y_reg == y_hi_reg);
    assign last_col = (x_reg == x_hi_reg);

    assign wr.we = (state_reg == R_SCAN) && covered;
    assign wr.x  = x_reg[CW-1:0];
    assign wr.y  = y_reg[CW-1:0];

    assign finish = ((state_reg == R_SETUP) && box_empty)
                 || ((state_reg == R_SCAN) && last_row && last_col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            x_reg     <= '0;
            y_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                R_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= R_CLIP;
                    end
                end
                R_CLIP:
                begin
                    state_reg <= R_MULT;
                end
                R_MULT:
                begin
                    state_reg <= R_SETUP;
                end
                R_SETUP:
                begin
                    if (box_empty)
                    begin
                        state_reg <= R_IDLE;
                    end
                    else
                    begin
                        state_reg <= R_SCAN;
                        x_reg     <= x_lo_reg;
                        y_reg     <= y_lo_reg;
                    end
                end
                R_SCAN:
                begin
                    if (last_row)
                    begin
                        if (last_col)
                        begin
                            state_reg <= R_IDLE;
                            x_reg     <= '0;
                            y_reg     <= '0;
                        end
                        else
                        begin
                            x_reg <= x_reg + XW'(1);
                            y_reg <= y_lo_reg;
                        end
                    end
                    else
                    begin
                        y_reg <= y_reg + XW'(1);
                    end
                end
                default:
                begin
                    state_reg <= R_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == R_IDLE) && start)
        begin
            e1x_reg <= $signed({bx[CW-1], bx}) - $signed({ax[CW-1], ax});
            e1y_reg <= $signed({by_coord[CW-1], by_coord}) - $signed({ay[CW-1], ay});
            e2x_reg <= $signed({cx[CW-1], cx}) - $signed({ax[CW-1], ax});
            e2y_reg <= $signed({cy[CW-1], cy}) - $signed({ay[CW-1], ay});
            x1_reg  <= ax;
            y1_reg  <= ay;
            lox_reg <= min3(ax, bx, cx);
            hix_reg <= max3(ax, bx, cx);
            loy_reg <= min3(ay, by_coord, cy);
            hiy_reg <= max3(ay, by_coord, cy);
        end

        if (state_reg == R_CLIP)
        begin
            x_lo_reg <= lox_c;
            x_hi_reg <= hix_c;
            y_lo_reg <= loy_c;
            y_hi_reg <= hiy_c;
            vx0_reg  <= lox_c - $signed({x1_reg[CW-1], x1_reg});
            vy0_reg  <= loy_c - $signed({y1_reg[CW-1], y1_reg});
        end

        if (state_reg == R_MULT)
        begin
            pda_reg <= e1x_reg * e2y_reg;
            pdb_reg <= e1y_reg * e2x_reg;
            psa_reg <= vx0_reg * e2y_reg;
            psb_reg <= vy0_reg * e2x_reg;
            pta_reg <= e1x_reg * vy0_reg;
            ptb_reg <= e1y_reg * vx0_reg;
        end

        if (state_reg == R_SETUP)
        begin
            det_reg   <= det_calc;
            s_reg     <= s_calc;
            t_reg     <= t_calc;
            s_col_reg <= s_calc;
            t_col_reg <= t_calc;
        end

        if (state_reg == R_SCAN)
        begin
            if (last_row)
            begin
                s_col_reg <= s_col_reg + EW'(e2y_reg);
                t_col_reg <= t_col_reg - EW'(e1y_reg);
                s_reg     <= s_col_reg + EW'(e2y_reg);
                t_reg     <= t_col_reg - EW'(e1y_reg);
            end
            else
            begin
                s_reg <= s_reg - EW'(e2x_reg);
                t_reg <= t_reg + EW'(e1x_reg);
            end
        end
    end

endmodule

FILE: hdl/triangle_fill_framebuffer.sv
// ----------------------------------------------------------------------------
// triangle_fill_framebuffer
// Command-driven framebuffer: clear, pixel write, pixel read, triangle fill.
// ----------------------------------------------------------------------------
// One command is taken when start is high and busy is low; each command gives
// exactly one result, shown for one cycle with done high, and the receiver
// cannot stall it. After acceptance busy stays high for a write in its write
// state, a read in the read and wait states (the registered memory read),
// a clear until every store word is zeroed (one store word per cycle
// through the single memory port), and a fill through the raster clip,
// multiply and setup states and a scan of the clipped bounding box, with no
// scan for a degenerate triangle or an empty box. The result is shown in the
// first cycle with busy low again, in which the next command may already be
// taken. The store holds undefined data after reset until cleared or written.
module triangle_fill_framebuffer #(
    parameter int MAX_WIDTH  = tffb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tffb_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            command,
    input  logic signed [tffb_pkg::COORD_W-1:0]   ax,
    input  logic signed [tffb_pkg::COORD_W-1:0]   ay,
    input  logic signed [tffb_pkg::COORD_W-1:0]   bx,
    input  logic signed [tffb_pkg::COORD_W-1:0]   by_coord,
    input  logic signed [tffb_pkg::COORD_W-1:0]   cx,
    input  logic signed [tffb_pkg::COORD_W-1:0]   cy,
    input  logic [tffb_pkg::COLOR_W-1:0]          paint,
    output logic                                  done,
    output logic [tffb_pkg::COLOR_W-1:0]          pixel_value,
    output logic                                  in_range,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tffb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tffb_pkg::DIM_REG_W-1:0]        cfg_data
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = tffb_pkg::COORD_W;
    localparam int XW     = tffb_pkg::EXT_W;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_CLEAR     = 3'd1;
    localparam logic [2:0] S_WRITE     = 3'd2;
    localparam logic [2:0] S_READ      = 3'd3;
    localparam logic [2:0] S_READ_WAIT = 3'd4;
    localparam logic [2:0] S_FILL      = 3'd5;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    function automatic logic [ADDR_W-1:0] addr_of(
        input logic [CW-1:0] x,
        input logic [CW-1:0] y
    );
        return ADDR_W'(int'(y) * MAX_WIDTH + int'(x));
    endfunction

    logic [2:0]                       state_reg;
    logic [ADDR_W-1:0]                clr_addr_reg;
    logic signed [CW-1:0]             ax_reg, ay_reg;
    logic [tffb_pkg::COLOR_W-1:0]     paint_reg;
    logic [tffb_pkg::DIM_REG_W-1:0]   frame_width_reg, frame_height_reg;
    logic                             done_reg;
    logic                             done_next;
    logic [tffb_pkg::COLOR_W-1:0]     pixel_value_reg;
    logic                             in_range_reg;

    logic signed [XW-1:0]             act_w, act_h;
    logic                             accept;
    logic                             pix_on;
    logic                             fill_start;
    logic                             fill_finish;
    tffb_pkg::pix_wr_t                fill_wr;
    logic                             mem_we;
    logic [ADDR_W-1:0]                mem_addr;
    logic [tffb_pkg::COLOR_W-1:0]     mem_wdata;
    logic [tffb_pkg::COLOR_W-1:0]     mem_rdata;

    assign act_w = tffb_pkg::active_dim(frame_width_reg, MAX_WIDTH);
    assign act_h = tffb_pkg::active_dim(frame_height_reg, MAX_HEIGHT);

    assign busy        = (state_reg != S_IDLE);
    assign accept      = start && !busy;
    assign fill_start  = accept && (command == tffb_pkg::CMD_FILL);
    assign cfg_ready   = 1'b1;
    assign done        = done_reg;
    assign pixel_value = pixel_value_reg;
    assign in_range    = in_range_reg;

    assign done_next = ((state_reg == S_CLEAR) && (clr_addr_reg == LAST_ADDR))
                    || (state_reg == S_WRITE)
                    || (state_reg == S_READ_WAIT)
                    || ((state_reg == S_FILL) && fill_finish);

    assign pix_on = !ax_reg[CW-1] && !ay_reg[CW-1]
                 && ($unsigned({1'b0, ax_reg}) < $unsigned(act_w))
                 && ($unsigned({1'b0, ay_reg}) < $unsigned(act_h));

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = paint_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_addr_reg;
                mem_wdata = '0;
            end
            S_WRITE:
            begin
                mem_we   = pix_on;
                mem_addr = pix_on ? addr_of(ax_reg, ay_reg) : '0;
            end
            S_READ:
            begin
                mem_addr = pix_on ? addr_of(ax_reg, ay_reg) : '0;
            end
            S_FILL:
            begin
                mem_we   = fill_wr.we;
                mem_addr = addr_of(fill_wr.x, fill_wr.y);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            clr_addr_reg     <= '0;
            frame_width_reg  <= tffb_pkg::DIM_RESET;
            frame_height_reg <= tffb_pkg::DIM_RESET;
            done_reg         <= 1'b0;
            pixel_value_reg  <= '0;
            in_range_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    tffb_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                    tffb_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        clr_addr_reg <= '0;
                        unique case (command)
                            tffb_pkg::CMD_CLEAR: state_reg <= S_CLEAR;
                            tffb_pkg::CMD_WRITE: state_reg <= S_WRITE;
                            tffb_pkg::CMD_READ:  state_reg <= S_READ;
                            tffb_pkg::CMD_FILL:  state_reg <= S_FILL;
                        endcase
                    end
                end
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (clr_addr_reg == LAST_ADDR)
                    begin
                        state_reg       <= S_IDLE;
                        pixel_value_reg <= '0;
                        in_range_reg    <= 1'b0;
                    end
                end
                S_WRITE:
                begin
                    state_reg       <= S_IDLE;
                    pixel_value_reg <= '0;
                    in_range_reg    <= pix_on;
                end
                S_READ:
                begin
                    state_reg <= S_READ_WAIT;
                end
                S_READ_WAIT:
                begin
                    state_reg       <= S_IDLE;
                    pixel_value_reg <= pix_on ? mem_rdata : '0;
                    in_range_reg    <= pix_on;
                end
                S_FILL:
                begin
                    if (fill_finish)
                    begin
                        state_reg       <= S_IDLE;
                        pixel_value_reg <= '0;
                        in_range_reg    <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg    <= ax;
            ay_reg    <= ay;
            paint_reg <= paint;
        end
    end

    tffb_raster u_raster (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (fill_start),
        .ax       (ax),
        .ay       (ay),
        .bx       (bx),
        .by_coord (by_coord),
        .cx       (cx),
        .cy       (cy),
        .act_w    (act_w),
        .act_h    (act_h),
        .wr       (fill_wr),
        .finish   (fill_finish)
    );

    tffb_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

FILE: tb/sv/fb_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fb_scoreboard_pkg
// Frame store predictor and in-order result scoreboard for the framebuffer
// engine bench. Each accepted request is applied to a private copy of the
// store and the screen size registers. The reply it must produce is queued
// and compared field by field with the next result the engine shows.
// ----------------------------------------------------------------------------
package fb_scoreboard_pkg;

    import tffb_pkg::*;

    localparam int STORE_COLS = DEF_MAX_WIDTH;
    localparam int STORE_ROWS = DEF_MAX_HEIGHT;

    typedef struct {
        logic [1:0]                command;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by_coord;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [COLOR_W-1:0]        paint;
    } fb_request_t;

    typedef struct {
        logic [COLOR_W-1:0] pixel_value;
        logic               in_range;
    } fb_reply_t;

    class frame_scoreboard;

        logic [COLOR_W-1:0]   frame_words [STORE_COLS*STORE_ROWS];
        logic [DIM_REG_W-1:0] width_reg;
        logic [DIM_REG_W-1:0] height_reg;
        fb_reply_t            replies_due [$];
        int                   mismatches;

        function new();
            width_reg  = DIM_RESET;
            height_reg = DIM_RESET;
            mismatches = 0;
            foreach (frame_words[i])
            begin
                frame_words[i] = '0;
            end
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_REG_W-1:0] data);
            if (idx == CFG_FRAME_WIDTH)
            begin
                width_reg = data;
            end
            else
            begin
                height_reg = data;
            end
        endfunction

        function int active_cols();
            return (int'(width_reg) > STORE_COLS) ? STORE_COLS : int'(width_reg);
        endfunction

        function int active_rows();
            return (int'(height_reg) > STORE_ROWS) ? STORE_ROWS : int'(height_reg);
        endfunction

        function bit visible(longint x, longint y);
            return x >= 0 && y >= 0 && x < active_cols() && y < active_rows();
        endfunction

        function void clear_store();
            foreach (frame_words[i])
            begin
                frame_words[i] = '0;
            end
        endfunction

        function void paint_triangle(fb_request_t r);
            longint x1, y1, x2, y2, x3, y3;
            longint e1x, e1y, e2x, e2y, det;
            longint lox, hix, loy, hiy;
            longint vx, vy, s, t;
            bit     hit;
            x1  = r.ax;
            y1  = r.ay;
            x2  = r.bx;
            y2  = r.by_coord;
            x3  = r.cx;
            y3  = r.cy;
            e1x = x2 - x1;
            e1y = y2 - y1;
            e2x = x3 - x1;
            e2y = y3 - y1;
            det = e1x * e2y - e1y * e2x;
            if (det == 0)
            begin
                return;
            end
            lox = (x1 < x2) ? x1 : x2;
            lox = (lox < x3) ? lox : x3;
            hix = (x1 > x2) ? x1 : x2;
            hix = (hix > x3) ? hix : x3;
            loy = (y1 < y2) ? y1 : y2;
            loy = (loy < y3) ? loy : y3;
            hiy = (y1 > y2) ? y1 : y2;
            hiy = (hiy > y3) ? hiy : y3;
            if (lox < 0)
            begin
                lox = 0;
            end
            if (loy < 0)
            begin
                loy = 0;
            end
            if (hix > active_cols() - 1)
            begin
                hix = active_cols() - 1;
            end
            if (hiy > active_rows() - 1)
            begin
                hiy = active_rows() - 1;
            end
            for (longint x = lox; x <= hix; x++)
            begin
                for (longint y = loy; y <= hiy; y++)
                begin
                    vx = x - x1;
                    vy = y - y1;
                    s  = vx * e2y - vy * e2x;
                    t  = e1x * vy - e1y * vx;
                    if (det > 0)
                    begin
                        hit = s >= 0 && t >= 0 && s + t <= det;
                    end
                    else
                    begin
                        hit = s <= 0 && t <= 0 && s + t >= det;
                    end
                    if (hit)
                    begin
                        frame_words[y * STORE_COLS + x] = r.paint;
                    end
                end
            end
        endfunction

        function void note_request(fb_request_t r);
            fb_reply_t rep;
            longint    px, py;
            px              = r.ax;
            py              = r.ay;
            rep.pixel_value = '0;
            rep.in_range    = 1'b0;
            case (r.command)
                CMD_CLEAR:
                begin
                    clear_store();
                end
                CMD_WRITE:
                begin
                    if (visible(px, py))
                    begin
                        frame_words[py * STORE_COLS + px] = r.paint;
                        rep.in_range = 1'b1;
                    end
                end
                CMD_READ:
                begin
                    if (visible(px, py))
                    begin
                        rep.pixel_value = frame_words[py * STORE_COLS + px];
                        rep.in_range    = 1'b1;
                    end
                end
                default:
                begin
                    paint_triangle(r);
                end
            endcase
            replies_due.push_back(rep);
        endfunction

        function void check_result(logic [COLOR_W-1:0] value, logic ok);
            fb_reply_t want;
            if (replies_due.size() == 0)
            begin
                $display("%0t: result with none pending: pixel_value %h in_range %b",
                         $time, value, ok);
                mismatches++;
                return;
            end
            want = replies_due.pop_front();
            if (value !== want.pixel_value)
            begin
                $display("%0t: pixel_value expected %h actual %h",
                         $time, want.pixel_value, value);
                mismatches++;
            end
            if (ok !== want.in_range)
            begin
                $display("%0t: in_range expected %b actual %b", $time, want.in_range, ok);
                mismatches++;
            end
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

    endclass

endpackage

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the triangle fill framebuffer engine.
// A directed opening covers clears, on and off screen pixel accesses, both
// triangle orientations, degenerate and extreme triangles. Random phases
// follow under several screen sizes and request gap rates, and every result
// is checked in order against the frame store predictor.
// ----------------------------------------------------------------------------
module tb_top;

    import tffb_pkg::*;
    import fb_scoreboard_pkg::*;

    localparam longint CYCLE_LIMIT   = 4_000_000;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     PHASES        = 6;

    localparam int PHASE_COLS [PHASES] = '{1, 127, 0, 37, 64, 13};
    localparam int PHASE_ROWS [PHASES] = '{1, 127, 0, 20, 64, 64};
    localparam int PHASE_IDLE [PHASES] = '{85, 17, 0, 85, 17, 0};
    localparam int PHASE_REQS [PHASES] = '{16, 20, 12, 21, 26, 22};

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        start     = 1'b0;
    logic                        busy;
    logic [1:0]                  command   = CMD_CLEAR;
    logic signed [COORD_W-1:0]   ax        = '0;
    logic signed [COORD_W-1:0]   ay        = '0;
    logic signed [COORD_W-1:0]   bx        = '0;
    logic signed [COORD_W-1:0]   by_coord  = '0;
    logic signed [COORD_W-1:0]   cx        = '0;
    logic signed [COORD_W-1:0]   cy        = '0;
    logic [COLOR_W-1:0]          paint     = '0;
    logic                        done;
    logic [COLOR_W-1:0]          pixel_value;
    logic                        in_range;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index = CFG_FRAME_WIDTH;
    logic [DIM_REG_W-1:0]        cfg_data  = DIM_RESET;

    frame_scoreboard board;
    longint          cycle_count     = 0;
    int              sender_idle_pct = 0;

    triangle_fill_framebuffer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .ax          (ax),
        .ay          (ay),
        .bx          (bx),
        .by_coord    (by_coord),
        .cx          (cx),
        .cy          (cy),
        .paint       (paint),
        .done        (done),
        .pixel_value (pixel_value),
        .in_range    (in_range),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            board.check_result(pixel_value, in_range);
        end
    end

    function automatic fb_request_t make_request(
        logic [1:0] cmd, int x1, int y1, int x2, int y2, int x3, int y3,
        logic [COLOR_W-1:0] color
    );
        fb_request_t r;
        r.command  = cmd;
        r.ax       = COORD_W'(x1);
        r.ay       = COORD_W'(y1);
        r.bx       = COORD_W'(x2);
        r.by_coord = COORD_W'(y2);
        r.cx       = COORD_W'(x3);
        r.cy       = COORD_W'(y3);
        r.paint    = color;
        return r;
    endfunction

    function automatic int pick_coord(int span);
        int roll;
        roll = $urandom_range(99);
        if (roll < 80)
        begin
            return int'($urandom_range(span + 7)) - 4;
        end
        else if (roll < 92)
        begin
            return int'($signed(COORD_W'($urandom)));
        end
        case ($urandom_range(3))
            0:       return -32768;
            1:       return 32767;
            2:       return -1;
            default: return 0;
        endcase
    endfunction

    function automatic int jitter();
        return int'($urandom_range(24)) - 12;
    endfunction

    function automatic fb_request_t random_request();
        fb_request_t r;
        int          roll, cols, rows, x1, y1, x2, y2, x3, y3;
        cols       = board.active_cols();
        rows       = board.active_rows();
        roll       = $urandom_range(99);
        r.paint    = $urandom;
        r.ax       = COORD_W'($urandom);
        r.ay       = COORD_W'($urandom);
        r.bx       = COORD_W'($urandom);
        r.by_coord = COORD_W'($urandom);
        r.cx       = COORD_W'($urandom);
        r.cy       = COORD_W'($urandom);
        if (roll < 5)
        begin
            r.command = CMD_CLEAR;
        end
        else if (roll < 30)
        begin
            r.command = CMD_WRITE;
            r.ax      = COORD_W'(pick_coord(cols));
            r.ay      = COORD_W'(pick_coord(rows));
        end
        else if (roll < 58)
        begin
            r.command = CMD_READ;
            r.ax      = COORD_W'(pick_coord(cols));
            r.ay      = COORD_W'(pick_coord(rows));
        end
        else
        begin
            r.command = CMD_FILL;
            roll      = $urandom_range(99);
            if (roll >= 10)
            begin
                x1 = int'($urandom_range(cols + 7)) - 4;
                y1 = int'($urandom_range(rows + 7)) - 4;
                x2 = x1 + jitter();
                y2 = y1 + jitter();
                if (roll < 18)
                begin
                    x3 = 2 * x2 - x1;
                    y3 = 2 * y2 - y1;
                end
                else
                begin
                    x3 = x1 + jitter();
                    y3 = y1 + jitter();
                end
                r.ax       = COORD_W'(x1);
                r.ay       = COORD_W'(y1);
                r.bx       = COORD_W'(x2);
                r.by_coord = COORD_W'(y2);
                r.cx       = COORD_W'(x3);
                r.cy       = COORD_W'(y3);
            end
        end
        return r;
    endfunction

    task automatic issue_command(input fb_request_t r);
        start    <= 1'b1;
        command  <= r.command;
        ax       <= r.ax;
        ay       <= r.ay;
        bx       <= r.bx;
        by_coord <= r.by_coord;
        cx       <= r.cx;
        cy       <= r.cy;
        paint    <= r.paint;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        board.note_request(r);
    endtask

    task automatic sender_pause();
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DIM_REG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        board.set_register(idx, data);
    endtask

    initial
    begin : stimulus
        fb_request_t opening [$];
        board = new();
        opening = '{
            make_request(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 32'h0),
            make_request(CMD_READ, 0, 0, 0, 0, 0, 0, 32'h0),
            make_request(CMD_WRITE, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF),
            make_request(CMD_WRITE, 63, 63, 0, 0, 0, 0, 32'h5A5A_5A5A),
            make_request(CMD_WRITE, -1, 5, 0, 0, 0, 0, 32'h1111_1111),
            make_request(CMD_WRITE, 64, 0, 0, 0, 0, 0, 32'h2222_2222),
            make_request(CMD_WRITE, -32768, 32767, 0, 0, 0, 0, 32'h3333_3333),
            make_request(CMD_READ, 0, 0, 0, 0, 0, 0, 32'h0),
            make_request(CMD_READ, 63, 63, 0, 0, 0, 0, 32'h0),
            make_request(CMD_READ, 63, 64, 0, 0, 0, 0, 32'h0),
            make_request(CMD_READ, 32767, -32768, 0, 0, 0, 0, 32'h0),
            make_request(CMD_FILL, 2, 2, 20, 3, 5, 18, 32'hAAAA_5555),
            make_request(CMD_FILL, 30, 30, 34, 50, 50, 32, 32'h0000_0000),
            make_request(CMD_FILL, 0, 0, 10, 10, 20, 20, 32'h1234_5678),
            make_request(CMD_FILL, -32768, -32768, 32767, -32768, -32768, 32767,
                         32'h0F0F_0F0F),
            make_request(CMD_FILL, -100, -100, -50, -90, -80, -40, 32'h7777_7777),
            make_request(CMD_FILL, 32767, 32767, -32768, 32767, 32767, -32768,
                         32'hFFFF_FFFF),
            make_request(CMD_READ, 5, 5, 0, 0, 0, 0, 32'h0),
            make_request(CMD_READ, 40, 35, 0, 0, 0, 0, 32'h0),
            make_request(CMD_READ, 63, 0, 0, 0, 0, 0, 32'h0),
            make_request(CMD_READ, 0, 63, 0, 0, 0, 0, 32'h0),
            make_request(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 32'h0),
            make_request(CMD_READ, 10, 10, 0, 0, 0, 0, 32'h0)
        };
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (opening[i])
        begin
            issue_command(opening[i]);
        end
        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            write_register(CFG_FRAME_WIDTH, DIM_REG_W'(PHASE_COLS[p]));
            write_register(CFG_FRAME_HEIGHT, DIM_REG_W'(PHASE_ROWS[p]));
            cfg_valid       <= 1'b0;
            sender_idle_pct = PHASE_IDLE[p];
            for (int n = 0; n < PHASE_REQS[p]; n++)
            begin
                sender_pause();
                issue_command(random_request());
            end
        end
        drain_results();
        if (board.mismatches == 0 && board.pending() == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
